// ----- src/midi_square_wave_polysynth_core_assert.svh -----
// Assertion macros shared by the checker of the square-wave synthesizer.
`ifndef MIDI_SQUARE_WAVE_POLYSYNTH_CORE_ASSERT_SVH
`define MIDI_SQUARE_WAVE_POLYSYNTH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSWPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("synth assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSWPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("synth assertion failed");

`endif

// ----- src/mswps_pkg.sv -----
// Types, constants and the note mapping function of the square-wave synthesizer.
`timescale 1ns / 1ps
`default_nettype none
package mswps_pkg;

  localparam int PHASE_W = 16;
  localparam int LEVEL_W = 5;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2
  } opcode_t;

  typedef struct packed {
    logic capture;
    logic write_event;
    logic sweep_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic ch_in_range;
    logic sweep_last;
  } dp_status_t;

  function automatic logic [15:0] octave_entry(input logic [3:0] idx);
    logic [15:0] val;
    case (idx)
      4'd0:    val = 16'h7E6F;
      4'd1:    val = 16'h7757;
      4'd2:    val = 16'h70A3;
      4'd3:    val = 16'h6A51;
      4'd4:    val = 16'h645A;
      4'd5:    val = 16'h5EB8;
      4'd6:    val = 16'h5967;
      4'd7:    val = 16'h5462;
      4'd8:    val = 16'h4FA5;
      4'd9:    val = 16'h4B2E;
      4'd10:   val = 16'h46F5;
      4'd11:   val = 16'h42F9;
      default: val = 16'h0000;
    endcase
    return val;
  endfunction

  // Distance below the top note is split into octave and semitone with a
  // reciprocal multiply by 171/2048, exact for distances up to 129.
  function automatic logic [15:0] note_to_step(input logic [6:0] note);
    logic [7:0]  span;
    logic [15:0] prod;
    logic [3:0]  octave;
    logic [7:0]  semi;
    logic [15:0] base;
    span   = 8'd131 - {1'b0, note};
    prod   = 16'(span) * 16'd171;
    octave = prod[14:11];
    semi   = span - 8'({4'd0, octave} * 8'd12);
    if (note <= 7'd1) begin
      base = {9'd0, note};
    end else begin
      base = octave_entry(semi[3:0]) >> octave;
    end
    return {base[14:0], 1'b0};
  endfunction

endpackage
`default_nettype wire

// ----- src/mswps_if.sv -----
// Valid/ready channel interfaces for the synthesizer's event input and sample output.
`timescale 1ns / 1ps
`default_nettype none
interface mswps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] channel;
  logic [6:0] note;

  modport source (output valid, output opcode, output channel, output note, input ready);
  modport sink (input valid, input opcode, input channel, input note, output ready);
endinterface

interface mswps_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] sample_level;

  modport source (output valid, output sample_level, input ready);
  modport sink (input valid, input sample_level, output ready);
endinterface
`default_nettype wire

// ----- src/mswps_datapath.sv -----
// Datapath: per-channel phase and step registers, sweep counter, level accumulator.
`timescale 1ns / 1ps
`default_nettype none
module mswps_datapath #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mswps_pkg::dp_cmd_t   cmd,
  output mswps_pkg::dp_status_t     status,
  input  wire logic [1:0]           in_opcode,
  input  wire logic [3:0]           in_channel,
  input  wire logic [6:0]           in_note,
  output logic [4:0]                out_level
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [15:0]     phase_r [NUM_CHANNELS];
  logic [15:0]     step_r  [NUM_CHANNELS];
  logic [CH_W-1:0] hi_r;
  logic [CH_W-1:0] cnt_r;
  logic [4:0]      acc_r;
  logic [CH_W-1:0] ev_ch_r;
  logic [15:0]     ev_step_r;
  logic [4:0]      level_r;

  logic [15:0] phase_sum;
  logic [4:0]  level_nxt;

  assign phase_sum = phase_r[cnt_r] + step_r[cnt_r];
  assign level_nxt = acc_r + {4'd0, phase_sum[15]};

  assign status.ch_in_range = ({1'b0, in_channel} < 5'(NUM_CHANNELS));
  assign status.sweep_last  = (cnt_r == hi_r);
  assign out_level          = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        phase_r[i] <= '0;
        step_r[i]  <= '0;
      end
      hi_r  <= '0;
      cnt_r <= '0;
      acc_r <= '0;
    end else begin
      if (cmd.write_event) begin
        phase_r[ev_ch_r] <= '0;
        step_r[ev_ch_r]  <= ev_step_r;
        if (ev_ch_r > hi_r) begin
          hi_r <= ev_ch_r;
        end
      end
      if (cmd.sweep_step) begin
        phase_r[cnt_r] <= phase_sum;
        if (cnt_r == hi_r) begin
          cnt_r <= '0;
          acc_r <= '0;
        end else begin
          cnt_r <= CH_W'(cnt_r + 1'b1);
          acc_r <= level_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ev_ch_r <= in_channel[CH_W-1:0];
      if (in_opcode == mswps_pkg::OP_NOTE_ON) begin
        ev_step_r <= mswps_pkg::note_to_step(in_note);
      end else begin
        ev_step_r <= '0;
      end
    end
    if (cmd.load_out) begin
      level_r <= level_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/mswps_ctrl.sv -----
// Controller: sequences event writes and tick sweeps and owns the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module mswps_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_opcode,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire mswps_pkg::dp_status_t status,
  output mswps_pkg::dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVENT = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_opcode == mswps_pkg::OP_TICK) begin
            state_nxt = S_SWEEP;
          end else if ((in_opcode == mswps_pkg::OP_NOTE_ON ||
                        in_opcode == mswps_pkg::OP_NOTE_OFF) && status.ch_in_range) begin
            state_nxt = S_EVENT;
          end
        end
      end
      S_EVENT: begin
        cmd.write_event = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_SWEEP: begin
        if (!status.sweep_last) begin
          cmd.sweep_step = 1'b1;
        end else if (out_free) begin
          cmd.sweep_step = 1'b1;
          cmd.load_out   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/midi_square_wave_polysynth_core.sv -----
// Top level of the polyphonic square-wave synthesizer.
// Usage:
//   in_if carries one item per event: opcode tick, note on or note off, with a
//   channel and a MIDI note. out_if carries one sample_level item per tick.
//   A note on or note off to a channel inside NUM_CHANNELS takes the accept
//   cycle and then a write cycle. Other non-tick items end in the accept
//   cycle. A tick is accepted and then sweeps channels 0 to H, where H is the
//   highest channel that a note on or note off has written since reset: the
//   sweep updates one channel's phase per cycle through a single adder, and
//   its last step loads the output register.
//   The output register holds a finished sample while new events are taken.
//   If a second tick finishes its sweep while that sample still waits, the
//   sweep holds at its last channel and in_if.ready stays low until
//   out_if.ready takes the waiting item.
//   Synchronous reset clears all phases, steps and the highest channel mark,
//   drops out_if.valid and leaves the block ready for input.
`timescale 1ns / 1ps
`default_nettype none
module midi_square_wave_polysynth_core #(
  parameter int NUM_CHANNELS = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mswps_in_if.sink   in_if,
  mswps_out_if.source out_if
);

  mswps_pkg::dp_cmd_t    cmd;
  mswps_pkg::dp_status_t status;
  logic                  in_ready;
  logic                  out_valid;
  logic [4:0]            out_level;

  mswps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .in_opcode (in_if.opcode),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mswps_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_opcode  (in_if.opcode),
    .in_channel (in_if.channel),
    .in_note    (in_if.note),
    .out_level  (out_level)
  );

  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid;
  assign out_if.sample_level = out_level;

endmodule
`default_nettype wire

// ----- src/mswps_checker.sv -----
// Port-level checker for the synthesizer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "midi_square_wave_polysynth_core_assert.svh"
module mswps_checker #(
  parameter int NUM_CHANNELS = 16
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_opcode,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [4:0] out_level
);

  logic in_acc;
  logic tick_acc;
  assign in_acc   = in_valid && in_ready;
  assign tick_acc = in_acc && (in_opcode == mswps_pkg::OP_TICK);

  `MSWPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `MSWPS_ASSERT_NEXT(a_tick_busy, clk, rst_n, tick_acc, !in_ready)
  `MSWPS_ASSERT_NEXT(a_tick_no_early_out, clk, rst_n, tick_acc && !out_valid, !out_valid)
  `MSWPS_ASSERT_NEXT(a_event_no_out, clk, rst_n, in_acc && !tick_acc, !$rose(out_valid))
  `MSWPS_ASSERT_NOW(a_level_range, clk, rst_n, out_valid, out_level <= 5'(NUM_CHANNELS))

endmodule

bind midi_square_wave_polysynth_core mswps_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_mswps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_opcode (in_if.opcode),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_level (out_if.sample_level)
);
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the polyphonic square-wave synthesizer core.
`timescale 1ns / 1ps
module tb;
  import mswps_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  class synth_tracker;
    logic [15:0] phase [16];
    logic [15:0] incr [16];
    logic [3:0]  top_ch;
    logic [4:0]  expected_levels [$];
    int          errors;

    function new();
      for (int i = 0; i < 16; i++) begin
        phase[i] = '0;
        incr[i]  = '0;
      end
      top_ch = '0;
      errors = 0;
    endfunction

    function logic [15:0] octave_top(int idx);
      case (idx)
        0:  return 16'h7E6F;
        1:  return 16'h7757;
        2:  return 16'h70A3;
        3:  return 16'h6A51;
        4:  return 16'h645A;
        5:  return 16'h5EB8;
        6:  return 16'h5967;
        7:  return 16'h5462;
        8:  return 16'h4FA5;
        9:  return 16'h4B2E;
        10: return 16'h46F5;
        11: return 16'h42F9;
        default: return 16'h0000;
      endcase
    endfunction

    function logic [15:0] note_incr(logic [6:0] n);
      int          span;
      logic [15:0] base;
      if (n <= 7'd1) begin
        base = {9'd0, n};
      end else begin
        span = 131 - int'(n);
        base = octave_top(span % 12) >> (span / 12);
      end
      return {base[14:0], 1'b0};
    endfunction

    function void take_event(logic [1:0] op, logic [3:0] ch, logic [6:0] n);
      logic [4:0] lvl;
      lvl = '0;
      if (op == OP_TICK) begin
        for (int i = 0; i <= int'(top_ch); i++) begin
          phase[i] = phase[i] + incr[i];
          lvl = lvl + phase[i][15];
        end
        expected_levels.push_back(lvl);
      end else if (op == OP_NOTE_ON || op == OP_NOTE_OFF) begin
        phase[ch] = '0;
        incr[ch]  = (op == OP_NOTE_ON) ? note_incr(n) : 16'h0000;
        if (ch > top_ch) top_ch = ch;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_level(logic [4:0] got);
      logic [4:0] want;
      if (expected_levels.size() == 0) begin
        report($sformatf("sample_level %0d arrived with no tick pending", got));
        return;
      end
      want = expected_levels.pop_front();
      if (got !== want) report($sformatf("sample_level got %0d, want %0d", got, want));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic calm;
  int   sent;
  int   cycle_count = 0;
  synth_tracker sb;

  mswps_in_if  in_if ();
  mswps_out_if out_if ();

  midi_square_wave_polysynth_core #(.NUM_CHANNELS(16)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_level(out_if.sample_level);
  end

  task send_event(input logic [1:0] op, input logic [3:0] ch, input logic [6:0] n);
    while (!calm && $urandom_range(99) < 22) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.opcode  <= op;
    in_if.channel <= ch;
    in_if.note    <= n;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.take_event(op, ch, n);
    if (op != OP_UNUSED) sent++;
  endtask

  task send_chord();
    logic [6:0] n;
    n = 7'($urandom_range(127));
    for (int c = 0; c < 16; c++) begin
      send_event(OP_NOTE_ON, 4'(c), ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : n);
    end
    repeat ($urandom_range(12, 2)) send_event(OP_TICK, 4'($urandom), 7'($urandom));
  endtask

  task send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      send_event(OP_TICK, 4'($urandom), 7'($urandom));
    end else if (pick < 75) begin
      send_event(OP_NOTE_ON, 4'($urandom), 7'($urandom));
    end else if (pick < 95) begin
      send_event(OP_NOTE_OFF, 4'($urandom), 7'($urandom));
    end else begin
      send_event(OP_UNUSED, 4'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_n          = 1'b0;
    calm           = 1'b0;
    sent           = 0;
    in_if.valid   <= 1'b0;
    in_if.opcode  <= OP_TICK;
    in_if.channel <= '0;
    in_if.note    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_event(OP_TICK, 4'd0, 7'd0);
    send_event(OP_NOTE_ON, 4'd0, 7'd127);
    send_event(OP_TICK, 4'd15, 7'd127);
    send_event(OP_TICK, 4'd0, 7'd0);
    send_event(OP_NOTE_ON, 4'd3, 7'd0);
    send_event(OP_NOTE_ON, 4'd2, 7'd1);
    send_event(OP_TICK, 4'd0, 7'd0);
    send_event(OP_UNUSED, 4'd15, 7'd127);
    send_event(OP_TICK, 4'd0, 7'd0);
    send_event(OP_NOTE_OFF, 4'd0, 7'd127);
    send_event(OP_TICK, 4'd0, 7'd0);
    send_event(OP_NOTE_ON, 4'd1, 7'd2);
    send_event(OP_NOTE_ON, 4'd0, 7'd127);
    send_event(OP_TICK, 4'd0, 7'd0);
    send_event(OP_NOTE_ON, 4'd15, 7'd64);
    send_event(OP_NOTE_ON, 4'd7, 7'd126);
    send_event(OP_TICK, 4'd0, 7'd0);
    send_event(OP_TICK, 4'd0, 7'd0);
    send_event(OP_NOTE_OFF, 4'd15, 7'd0);
    send_event(OP_NOTE_ON, 4'd10, 7'd85);
    send_event(OP_TICK, 4'd9, 7'd42);
    send_event(OP_TICK, 4'd6, 7'd21);

    while (sent < ITEM_TARGET) begin
      calm <= (sent >= 500 && sent < 700);
      if ($urandom_range(99) < 6) send_chord();
      else send_random();
    end
    calm <= 1'b0;
    in_if.valid <= 1'b0;

    while (sb.expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
